/* design/sst_pkg.sv */
// sst_pkg: opcodes, status codes and sequencer state type for sorted_set_table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

	// request opcodes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;

	// result status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_DUP     = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	// sequencer states, one-hot
	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_SCAN_RD  = 7'b0000010,
		S_SCAN_CMP = 7'b0000100,
		S_DECIDE   = 7'b0001000,
		S_MOVE_RD  = 7'b0010000,
		S_MOVE_WR  = 7'b0100000,
		S_FINISH   = 7'b1000000
	} state_t;

endpackage

`default_nettype wire

/* design/sorted_set_table.sv */
// sorted_set_table: ordered set of distinct signed 32-bit values in a single-port memory
// depends on sst_pkg for opcodes, status codes and the state type
`timescale 1ns / 1ps
`default_nettype none

// Keeps up to CAPACITY distinct signed values in ascending order in one memory with a
// single read/write port and registered read data. A request (insert, remove or search;
// opcode 3 acts as search) walks the entries from the bottom until it reaches the first
// entry not less than the key, reading and then comparing each entry, then an insert or
// remove shifts the entries above that point by one place, reading and then writing each
// entry moved, all through the single memory port. A finished result is held until the
// previous result has left the output register. The request channel is ready only
// between requests; the result sits in an output register, so a new request is taken
// while a result waits. entry_count is the stored count truncated to 5 bits. No clearing
// pass after reset.
module sorted_set_table #(
	parameter int CAPACITY = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire  [1:0]        opcode,
	input  wire signed [31:0] key_value,
	output logic              out_valid,
	input  wire               out_ready,
	output logic [1:0]        status,
	output logic              found,
	output logic [4:0]        entry_count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] ONE = CW'(1);
	localparam logic [CW-1:0] CAP = CW'(CAPACITY);

	sst_pkg::state_t state_q;

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      pos_q;
	logic [CW-1:0]      k_q;
	logic [1:0]         op_q;
	logic signed [31:0] key_q;
	logic               present_q;
	logic [1:0]         res_status_q;
	logic signed [31:0] rd_q;

	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic               out_found_q;
	logic [CW-1:0]      out_count_q;

	logic signed [31:0] mem [CAPACITY];

	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic signed [31:0] wr_data;

	logic [CW-1:0]      k_dn;
	logic [CW-1:0]      k_up;
	logic [CW+4:0]      count_ext;

	assign k_dn = k_q - ONE;
	assign k_up = k_q + ONE;

	// handshake and result ports
	assign in_ready    = (state_q == sst_pkg::S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign found       = out_found_q;
	assign count_ext   = {5'd0, out_count_q};
	assign entry_count = count_ext[4:0];

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = pos_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = k_q[AW-1:0];
		wr_data = rd_q;
		unique case (state_q)
			sst_pkg::S_SCAN_RD: begin
				rd_en   = (pos_q != count_q);
				rd_addr = pos_q[AW-1:0];
			end
			sst_pkg::S_MOVE_RD: begin
				if (op_q == sst_pkg::OP_INSERT) begin
					if (k_q == pos_q) begin
						wr_en   = 1'b1;
						wr_data = key_q;
					end else begin
						rd_en   = 1'b1;
						rd_addr = k_dn[AW-1:0];
					end
				end else if (k_up < count_q) begin
					rd_en   = 1'b1;
					rd_addr = k_up[AW-1:0];
				end
			end
			sst_pkg::S_MOVE_WR: begin
				wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// entry storage, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sst_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result leaves unless a new one is loaded in the same cycle
			if (out_valid_q && out_ready && (state_q != sst_pkg::S_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				sst_pkg::S_IDLE: begin
					if (in_valid) begin
						op_q    <= opcode;
						key_q   <= key_value;
						pos_q   <= '0;
						state_q <= sst_pkg::S_SCAN_RD;
					end
				end
				sst_pkg::S_SCAN_RD: begin
					if (pos_q == count_q) begin
						present_q <= 1'b0;
						state_q   <= sst_pkg::S_DECIDE;
					end else begin
						state_q <= sst_pkg::S_SCAN_CMP;
					end
				end
				sst_pkg::S_SCAN_CMP: begin
					// shared signed compare of the entry against the key
					if (rd_q < key_q) begin
						pos_q   <= pos_q + ONE;
						state_q <= sst_pkg::S_SCAN_RD;
					end else begin
						present_q <= (rd_q == key_q);
						state_q   <= sst_pkg::S_DECIDE;
					end
				end
				sst_pkg::S_DECIDE: begin
					case (op_q)
						sst_pkg::OP_INSERT: begin
							if (present_q) begin
								res_status_q <= sst_pkg::ST_DUP;
								state_q      <= sst_pkg::S_FINISH;
							end else if (count_q >= CAP) begin
								res_status_q <= sst_pkg::ST_FULL;
								state_q      <= sst_pkg::S_FINISH;
							end else begin
								res_status_q <= sst_pkg::ST_DONE;
								k_q          <= count_q;
								state_q      <= sst_pkg::S_MOVE_RD;
							end
						end
						sst_pkg::OP_REMOVE: begin
							if (present_q) begin
								res_status_q <= sst_pkg::ST_DONE;
								k_q          <= pos_q;
								state_q      <= sst_pkg::S_MOVE_RD;
							end else begin
								res_status_q <= sst_pkg::ST_MISSING;
								state_q      <= sst_pkg::S_FINISH;
							end
						end
						default: begin
							res_status_q <= present_q ? sst_pkg::ST_DONE : sst_pkg::ST_MISSING;
							state_q      <= sst_pkg::S_FINISH;
						end
					endcase
				end
				sst_pkg::S_MOVE_RD: begin
					if (op_q == sst_pkg::OP_INSERT) begin
						// new value lands once the gap reaches its position
						if (k_q == pos_q) begin
							count_q <= count_q + ONE;
							state_q <= sst_pkg::S_FINISH;
						end else begin
							state_q <= sst_pkg::S_MOVE_WR;
						end
					end else if (k_up < count_q) begin
						state_q <= sst_pkg::S_MOVE_WR;
					end else begin
						count_q <= count_q - ONE;
						state_q <= sst_pkg::S_FINISH;
					end
				end
				sst_pkg::S_MOVE_WR: begin
					k_q     <= (op_q == sst_pkg::OP_INSERT) ? k_dn : k_up;
					state_q <= sst_pkg::S_MOVE_RD;
				end
				sst_pkg::S_FINISH: begin
					// load the output register once the previous result has left
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_found_q  <= present_q;
						out_count_q  <= count_q;
						state_q      <= sst_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= sst_pkg::S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
